/* rtl/core/nlp_pkg.sv */
// ----------------------------------------------------------------------------
// nlp_pkg
// Types, character codes and helpers shared by the literal parser modules.
// ----------------------------------------------------------------------------
package nlp_pkg;

  // status codes
  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_NAN = 2'd1;
  localparam logic [1:0] ST_OVF = 2'd2;

  // bit positions inside class / overflow flag vectors
  localparam int CLS_HEX = 0;
  localparam int CLS_DEC = 1;
  localparam int CLS_BIN = 2;

  // character codes
  localparam logic [7:0] CH_0    = 8'h30;
  localparam logic [7:0] CH_1    = 8'h31;
  localparam logic [7:0] CH_9    = 8'h39;
  localparam logic [7:0] CH_A_UP = 8'h41;
  localparam logic [7:0] CH_F_UP = 8'h46;
  localparam logic [7:0] CH_A_LO = 8'h61;
  localparam logic [7:0] CH_F_LO = 8'h66;
  localparam logic [7:0] CH_B_UP = 8'h42;
  localparam logic [7:0] CH_B_LO = 8'h62;
  localparam logic [7:0] CH_X_UP = 8'h58;
  localparam logic [7:0] CH_X_LO = 8'h78;

  // largest decimal accumulator that can take one more digit (2^32 / 10)
  localparam logic [31:0] DEC_LIMIT = 32'd429496729;
  localparam logic [3:0]  DEC_LAST_DIGIT = 4'd5;

  localparam logic [4:0] HEX_NONE = 5'd16;

  typedef struct packed {
    logic [1:0]  position;
    logic        lead_zero;
    logic        hex_prefixed;
    logic [31:0] hex_acc;
    logic [31:0] dec_acc;
    logic [31:0] bin_acc;
    logic [2:0]  ovf;
    logic [2:0]  cls;
  } parse_state_t;

  localparam parse_state_t STATE_RESET = '{
    position:     2'd0,
    lead_zero:    1'b0,
    hex_prefixed: 1'b0,
    hex_acc:      32'd0,
    dec_acc:      32'd0,
    bin_acc:      32'd0,
    ovf:          3'b000,
    cls:          3'b111
  };

  typedef struct packed {
    logic [31:0] value;
    logic [1:0]  status;
  } result_t;

  // hex digit value, HEX_NONE if not a hex digit
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] d;
    d = HEX_NONE;
    if (c >= CH_0 && c <= CH_9) begin
      d = {1'b0, c[3:0]};
    end else if ((c >= CH_A_LO && c <= CH_F_LO) || (c >= CH_A_UP && c <= CH_F_UP)) begin
      d = {1'b0, c[3:0]} + 5'd9;
    end
    return d;
  endfunction

endpackage

/* rtl/core/nlp_in_if.sv */
// ----------------------------------------------------------------------------
// nlp_in_if
// Character channel: one token character per word with a last mark.
// ----------------------------------------------------------------------------
interface nlp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       last;

  modport source (output valid, output ch, output last, input ready);
  modport sink   (input valid, input ch, input last, output ready);
endinterface

/* rtl/core/nlp_out_if.sv */
// ----------------------------------------------------------------------------
// nlp_out_if
// Result channel: parsed value and status, one word per token.
// ----------------------------------------------------------------------------
interface nlp_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] value;
  logic [1:0]  status;

  modport source (output valid, output value, output status, input ready);
  modport sink   (input valid, input value, input status, output ready);
endinterface

/* rtl/core/nlp_step.sv */
// ----------------------------------------------------------------------------
// nlp_step
// Per-character update of the three accumulators and the token result.
// ----------------------------------------------------------------------------
module nlp_step (
  input  nlp_pkg::parse_state_t state,
  input  logic [7:0]            ch,
  input  logic                  last,
  output nlp_pkg::parse_state_t state_next,
  output nlp_pkg::result_t      result
);
  import nlp_pkg::*;

  parse_state_t upd;
  logic [4:0]   hd;
  logic [3:0]   dd;
  logic         is_dec;
  logic         is_bin;
  logic         prefixed_now;
  logic         is_b;

  always_comb begin
    upd    = state;
    hd     = hex_digit(ch);
    dd     = ch[3:0];
    is_dec = (ch >= CH_0) && (ch <= CH_9);
    is_bin = (ch == CH_0) || (ch == CH_1);
    is_b   = (ch == CH_B_LO) || (ch == CH_B_UP);

    // prefix tracking and hex body
    if (state.position == 2'd0) begin
      upd.lead_zero = (ch == CH_0);
    end else if (state.position == 2'd1) begin
      upd.hex_prefixed = state.lead_zero && ((ch == CH_X_LO) || (ch == CH_X_UP));
    end else if (state.hex_prefixed) begin
      if (hd[4]) begin
        upd.cls[CLS_HEX] = 1'b0;
      end else if (!state.ovf[CLS_HEX]) begin
        if (state.hex_acc[31:28] != 4'd0) begin
          upd.ovf[CLS_HEX] = 1'b1;
        end else begin
          upd.hex_acc = {state.hex_acc[27:0], hd[3:0]};
        end
      end
    end
    prefixed_now = (state.position != 2'd0) && upd.hex_prefixed;

    // decimal: acc * 10 + d as two shifts and adds
    if (is_dec) begin
      if (!state.ovf[CLS_DEC]) begin
        if (state.dec_acc > DEC_LIMIT || (state.dec_acc == DEC_LIMIT && dd > DEC_LAST_DIGIT))
        begin
          upd.ovf[CLS_DEC] = 1'b1;
        end else begin
          upd.dec_acc = {state.dec_acc[28:0], 3'b000} + {state.dec_acc[30:0], 1'b0}
                      + {28'd0, dd};
        end
      end
    end else begin
      upd.cls[CLS_DEC] = 1'b0;
    end

    // binary
    if (is_bin) begin
      if (!state.ovf[CLS_BIN]) begin
        if (state.bin_acc[31]) begin
          upd.ovf[CLS_BIN] = 1'b1;
        end else begin
          upd.bin_acc = {state.bin_acc[30:0], ch[0]};
        end
      end
    end else begin
      upd.cls[CLS_BIN] = 1'b0;
    end

    // token result, only meaningful on the last character
    result.value  = 32'd0;
    result.status = ST_NAN;
    if (prefixed_now) begin
      if (state.position[1] && upd.cls[CLS_HEX]) begin
        if (upd.ovf[CLS_HEX]) begin
          result.status = ST_OVF;
        end else begin
          result.status = ST_OK;
          result.value  = upd.hex_acc;
        end
      end
    end else if (is_b) begin
      if (state.cls[CLS_BIN]) begin
        if (upd.ovf[CLS_BIN]) begin
          result.status = ST_OVF;
        end else begin
          result.status = ST_OK;
          result.value  = upd.bin_acc;
        end
      end
    end else if (upd.cls[CLS_DEC]) begin
      if (upd.ovf[CLS_DEC]) begin
        result.status = ST_OVF;
      end else begin
        result.status = ST_OK;
        result.value  = upd.dec_acc;
      end
    end

    if (last) begin
      state_next = STATE_RESET;
    end else begin
      state_next = upd;
      if (state.position != 2'd3) begin
        state_next.position = state.position + 2'd1;
      end
    end
  end

endmodule

/* rtl/core/nlp_out_reg.sv */
// ----------------------------------------------------------------------------
// nlp_out_reg
// Result register driving the output channel.
// ----------------------------------------------------------------------------
module nlp_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  nlp_pkg::result_t load_data,
  output logic             can_load,
  nlp_out_if.source        res
);
  import nlp_pkg::*;

  logic    valid;
  result_t data;

  assign can_load = !valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (can_load) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_load) begin
      data <= load_data;
    end
  end

  assign res.valid  = valid;
  assign res.value  = data.value;
  assign res.status = data.status;

endmodule

/* rtl/core/numeric_literal_parser_top.sv */
// ----------------------------------------------------------------------------
// numeric_literal_parser_top
// ASCII integer literal parser: hex (0x / 0X prefix), binary (b / B suffix)
// and decimal tokens, one character per word, one 32-bit result per token.
// ----------------------------------------------------------------------------
// Usage
//   tok : character words (ch, last). last marks the final char of a token.
//   res : one word per token (value, status); status 0 ok, 1 not a number,
//         2 exceeds 32 bits. value is zero unless status is ok.
// Throughput: one character per cycle, sustained, with no gaps between
//   tokens, unless a last character is stalled (see Stall below).
// Result path: the last character waits in the input register until the
//   output register has room; its result is then written to the output
//   register, which presents the result word.
// Stall: while the result register is held by a low res.ready, characters
//   that do not end a token keep flowing; a last character waits in the
//   input register, which then takes nothing more until the result drains.
// Reset: clears both valid flags and returns the parse state to its start
//   (no prefix, all classes possible, accumulators zero). The state also
//   returns to start after every last character.
// ----------------------------------------------------------------------------
module numeric_literal_parser_top (
  input  logic      clk,
  input  logic      rst,
  nlp_in_if.sink    tok,
  nlp_out_if.source res
);
  import nlp_pkg::*;

  // input register
  logic       s1_valid;
  logic [7:0] s1_ch;
  logic       s1_last;

  // parse state
  parse_state_t state;
  parse_state_t state_next;
  result_t      step_result;

  logic can_load;
  logic s1_adv;

  // a non-last char always retires; a last char needs room for its result
  assign s1_adv    = s1_valid && (!s1_last || can_load);
  assign tok.ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (tok.ready) begin
      s1_valid <= tok.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tok.ready && tok.valid) begin
      s1_ch   <= tok.ch;
      s1_last <= tok.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_RESET;
    end else if (s1_adv) begin
      state <= state_next;
    end
  end

  nlp_step u_step (
    .state      (state),
    .ch         (s1_ch),
    .last       (s1_last),
    .state_next (state_next),
    .result     (step_result)
  );

  nlp_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (s1_adv && s1_last),
    .load_data (step_result),
    .can_load  (can_load),
    .res       (res)
  );

  // ---- assertions ----

  // state goes back to start after a token ends
  a_reset_after_last: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && s1_last) |=> (state == STATE_RESET))
    else $error("parse state not cleared after last character");

  // hex prefix can only follow a leading zero
  a_prefix_needs_zero: assert property (@(posedge clk) disable iff (rst)
    state.hex_prefixed |-> state.lead_zero)
    else $error("hex prefix set without leading zero");

  // a failed token carries a zero value
  a_zero_on_fail: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.status != ST_OK) |-> (res.value == 32'd0))
    else $error("nonzero value with failing status");

  // a last char held in the input register blocks new characters
  a_hold_last: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_last && !can_load) |-> !tok.ready)
    else $error("input taken while last character is stalled");

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the literal parser. Feeds hex, decimal and binary tokens
// plus noise and damaged tokens, one character per word, with random gaps
// and stalls and one long output hold-off. An internal model predicts each
// result word, which is compared field by field as it comes out.
// ----------------------------------------------------------------------------
module tb;
  import nlp_pkg::*;

  localparam int CYCLE_LIMIT = 60000;
  localparam int RANDOM_CHARS = 200;
  localparam int LONG_HOLD = 120;   // output hold-off, long enough to fill the block
  localparam int HOLD_AT = 12;      // result count at which the hold-off happens

  typedef logic [7:0] chars_t[$];

  // Tracks the parse state of the current token and keeps the results that
  // are still to come out, oldest first.
  class literal_checker;
    parse_state_t parse = STATE_RESET;
    result_t      due_results[$];
    int           failures = 0;

    function int pending();
      return due_results.size();
    endfunction

    // One accepted character; queues a result when it ends the token.
    function void take_char(input logic [7:0] c, input logic fin);
      logic [1:0] p;
      logic       bin_before;
      logic       prefixed_now;
      logic       hex_ok;
      logic [3:0] hv;
      result_t    r;
      p = parse.position;
      bin_before = parse.cls[CLS_BIN];

      // first char may be the 0 of a prefix, second may be the x
      if (p == 2'd0) begin
        parse.lead_zero = (c == CH_0);
      end else if (p == 2'd1) begin
        parse.hex_prefixed = parse.lead_zero && (c == CH_X_LO || c == CH_X_UP);
      end else if (parse.hex_prefixed) begin
        hex_ok = 1'b1;
        hv = c[3:0];
        if ((c >= CH_A_LO && c <= CH_F_LO) || (c >= CH_A_UP && c <= CH_F_UP)) begin
          hv = c[3:0] + 4'd9;
        end else if (!(c >= CH_0 && c <= CH_9)) begin
          hex_ok = 1'b0;
        end
        if (!hex_ok) begin
          parse.cls[CLS_HEX] = 1'b0;
        end else if (!parse.ovf[CLS_HEX]) begin
          if (parse.hex_acc[31:28] != 4'd0) parse.ovf[CLS_HEX] = 1'b1;
          else parse.hex_acc = {parse.hex_acc[27:0], hv};
        end
      end
      prefixed_now = (p != 2'd0) && parse.hex_prefixed;

      if (c >= CH_0 && c <= CH_9) begin
        if (!parse.ovf[CLS_DEC]) begin
          if (parse.dec_acc > DEC_LIMIT ||
              (parse.dec_acc == DEC_LIMIT && c[3:0] > DEC_LAST_DIGIT)) begin
            parse.ovf[CLS_DEC] = 1'b1;
          end else begin
            parse.dec_acc = parse.dec_acc * 32'd10 + {28'd0, c[3:0]};
          end
        end
      end else begin
        parse.cls[CLS_DEC] = 1'b0;
      end

      if (c == CH_0 || c == CH_1) begin
        if (!parse.ovf[CLS_BIN]) begin
          if (parse.bin_acc[31]) parse.ovf[CLS_BIN] = 1'b1;
          else parse.bin_acc = {parse.bin_acc[30:0], c[0]};
        end
      end else begin
        parse.cls[CLS_BIN] = 1'b0;
      end

      if (!fin) begin
        if (p != 2'd3) parse.position = p + 2'd1;
        return;
      end

      r.value = 32'd0;
      r.status = ST_NAN;
      if (prefixed_now) begin
        if (p >= 2'd2 && parse.cls[CLS_HEX]) begin
          if (parse.ovf[CLS_HEX]) r.status = ST_OVF;
          else begin
            r.status = ST_OK;
            r.value = parse.hex_acc;
          end
        end
      end else if (c == CH_B_LO || c == CH_B_UP) begin
        if (bin_before) begin
          if (parse.ovf[CLS_BIN]) r.status = ST_OVF;
          else begin
            r.status = ST_OK;
            r.value = parse.bin_acc;
          end
        end
      end else if (parse.cls[CLS_DEC]) begin
        if (parse.ovf[CLS_DEC]) r.status = ST_OVF;
        else begin
          r.status = ST_OK;
          r.value = parse.dec_acc;
        end
      end
      due_results = {due_results, r};
      parse = STATE_RESET;
    endfunction

    // One accepted result word against the oldest prediction.
    function void match_result(input logic [31:0] v, input logic [1:0] s);
      result_t want;
      if (due_results.size() == 0) begin
        failures++;
        $display("[%0t] unexpected result: value=%0d status=%0d", $time, v, s);
        return;
      end
      want = due_results.pop_front();
      if (v !== want.value) begin
        failures++;
        $display("[%0t] value mismatch: expected %0d, got %0d", $time, want.value, v);
      end
      if (s !== want.status) begin
        failures++;
        $display("[%0t] status mismatch: expected %0d, got %0d", $time, want.status, s);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  bit   calm = 1'b0;   // when set, neither side idles
  int   cycle_count = 0;

  nlp_in_if  tok_if ();
  nlp_out_if res_if ();

  literal_checker chk = new;

  numeric_literal_parser_top uut (
    .clk (clk),
    .rst (rst),
    .tok (tok_if),
    .res (res_if)
  );

  // Directed tokens: range ends of every form, prefix corner cases, junk after
  // the prefix, bare b, leading zeros, invalid-but-huge, high characters.
  string directed_tokens[] = '{
    "0", "7", "4294967295", "4294967296", "0000000000004294967295",
    "99999999999x", "0x1b", "0x", "0X", "0xFFFFFFFF", "0x100000000",
    "0x000000000001", "0x 1", "0x+1", "0xx1", "0XaBcDeF", "b", "B", "0b",
    "1011B", "11111111111111111111111111111111b",
    "100000000000000000000000000000000b", "2b", "1x", "-1", "12a", " 5",
    "\377\200"
  };

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // Monitor: values read here are the ones present at the edge, since every
  // driver in the bench and the block update by nonblocking assignment.
  always @(posedge clk) begin
    if (rst === 1'b0) begin
      if (res_if.valid && res_if.ready) chk.match_result(res_if.value, res_if.status);
      if (tok_if.valid && tok_if.ready) chk.take_char(tok_if.ch, tok_if.last);
    end
  end

  function automatic chars_t text(input string s);
    chars_t q;
    for (int i = 0; i < s.len(); i++) q = {q, s[i]};
    return q;
  endfunction

  // Random token: mostly well-formed hex / decimal / binary with random
  // content, plus raw noise, damaged tokens and short corner tokens.
  function automatic chars_t make_token();
    chars_t q;
    string  hex_set;
    string  junk_set;
    int     shape;
    int     form;
    int     n;
    int     pos;
    bit     big;
    hex_set = "0123456789abcdefABCDEF";
    junk_set = " +-xXg._";
    shape = $urandom_range(0, 9);
    big = ($urandom_range(0, 7) == 0);

    if (shape == 6) begin
      n = $urandom_range(1, 4);
      repeat (n) q = {q, 8'($urandom_range(0, 255))};
      return q;
    end
    if (shape == 9) begin
      case ($urandom_range(0, 4))
        0: q = text("0x");
        1: q = text("0X");
        2: q = text("b");
        3: q = text("B");
        default: q = text("0");
      endcase
      return q;
    end

    form = (shape <= 5) ? shape / 2 : $urandom_range(0, 2);
    case (form)
      0: begin
        q = {q, CH_0};
        q = {q, ($urandom_range(0, 1) ? CH_X_UP : CH_X_LO)};
        if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 4)) q = {q, CH_0};
        n = big ? $urandom_range(8, 10) : $urandom_range(1, 7);
        repeat (n) q = {q, hex_set[$urandom_range(0, 21)]};
      end
      1: begin
        if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) q = {q, CH_0};
        if (big && $urandom_range(0, 1)) begin
          // straddle the 32-bit decimal limit
          q = {q, text("42949672")};
          repeat (2) q = {q, 8'(CH_0 + $urandom_range(0, 9))};
        end else begin
          n = big ? $urandom_range(10, 12) : $urandom_range(1, 9);
          repeat (n) q = {q, 8'(CH_0 + $urandom_range(0, 9))};
        end
      end
      default: begin
        n = big ? $urandom_range(30, 34) : $urandom_range(0, 12);
        repeat (n) q = {q, ($urandom_range(0, 1) ? CH_1 : CH_0)};
        q = {q, ($urandom_range(0, 1) ? CH_B_UP : CH_B_LO)};
      end
    endcase

    // damage: overwrite one character or tack junk on the end
    if (shape >= 7) begin
      pos = $urandom_range(0, q.size());
      if (pos == q.size()) q = {q, junk_set[$urandom_range(0, 7)]};
      else q[pos] = 8'($urandom_range(0, 255));
    end
    return q;
  endfunction

  // Sender: a random gap before each word, valid held until ready.
  task automatic send_token(input chars_t t);
    int gap;
    for (int i = 0; i < t.size(); i++) begin
      gap = calm ? 0 : $urandom_range(0, 3);
      if (gap != 0) begin
        tok_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      tok_if.valid <= 1'b1;
      tok_if.ch    <= t[i];
      tok_if.last  <= (i == t.size() - 1);
      do @(posedge clk); while (!tok_if.ready);
    end
  endtask

  // Receiver: a random stall before each word; once, a long hold-off while
  // the sender keeps going, so the block backs up and drops tok.ready.
  initial begin : result_sink
    int stall;
    int taken;
    taken = 0;
    res_if.ready <= 1'b0;
    @(posedge clk);
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 3);
      if (taken == HOLD_AT) stall = LONG_HOLD;
      if (stall != 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk); while (!res_if.valid);
      taken++;
    end
  end

  initial begin : char_source
    chars_t t;
    int     sent;
    rst          <= 1'b1;
    tok_if.valid <= 1'b0;
    tok_if.ch    <= 8'd0;
    tok_if.last  <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_tokens[i]) send_token(text(directed_tokens[i]));

    // random part; every so often a token goes through with no idling
    sent = 0;
    while (sent < RANDOM_CHARS) begin
      calm = ($urandom_range(0, 5) == 0);
      t = make_token();
      send_token(t);
      sent += t.size();
    end
    tok_if.valid <= 1'b0;
    calm = 1'b0;

    // let the monitor log the final word before looking at the queue
    @(posedge clk);

    // drain; the watchdog catches a result that never comes
    while (chk.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (chk.failures == 0 && chk.pending() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end
endmodule
